[hdl/cau_pkg.sv]
// Package for the complex arithmetic unit: word types, mode and status codes,
// fixed-point constants, the CORDIC angle table and saturation helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int DW       = 16;                  // operand and result width
    localparam int FB       = 12;                  // fraction bits
    localparam int CS       = 14;                  // CORDIC iterations
    localparam int DIV_BITS = DW + 1;              // quotient bits resolved
    localparam int DIV_PRE  = DIV_BITS - FB;       // numerator bits fed in by the steps
    localparam int ITER     = (DIV_BITS > CS + 3) ? DIV_BITS : CS + 3;
    localparam int PW       = 2 * DW + 1;          // sum of two products
    localparam int CG       = 60 - DW;             // vectoring input scale
    localparam int PX_W     = CG + DW + 2;         // vectoring x/y width
    localparam int PL_W     = DW + 32;             // rotation x/y width
    localparam int AZ_W     = 36;                  // angle accumulator width
    localparam int RS_PH    = 30 - FB;             // angle scale shift

    localparam logic signed [AZ_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [AZ_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [AZ_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [30:0]     INV_GAIN    = 31'sh26DD3B6A;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_MUL   = 4'd2,
        MODE_DIV   = 4'd3,
        MODE_CONJ  = 4'd4,
        MODE_NEG   = 4'd5,
        MODE_MAG   = 4'd6,
        MODE_PHASE = 4'd7,
        MODE_POLAR = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]           mode;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic [1:0]           status;
    } t_out;

    // result of the short modes, carried beside the long units
    typedef struct packed {
        logic [3:0]           mode;
        logic signed [DW-1:0] s_re;
        logic signed [DW-1:0] s_im;
        logic                 s_ov;
    } t_side;

    function automatic logic [29:0] atan_ang(input int i);
        case (i)
            0:  return 30'h3243F6A8;
            1:  return 30'h1DAC6705;
            2:  return 30'h0FADBAFC;
            3:  return 30'h07F56EA6;
            4:  return 30'h03FEAB76;
            5:  return 30'h01FFD55B;
            6:  return 30'h00FFFAAA;
            7:  return 30'h007FFF55;
            8:  return 30'h003FFFEA;
            9:  return 30'h001FFFFD;
            10: return 30'h000FFFFF;
            11: return 30'h0007FFFF;
            12: return 30'h0003FFFF;
            13: return 30'h0001FFFF;
            14: return 30'h0000FFFF;
            15: return 30'h00007FFF;
            16: return 30'h00003FFF;
            17: return 30'h00001FFF;
            18: return 30'h00000FFF;
            19: return 30'h000007FF;
            20: return 30'h000003FF;
            21: return 30'h000001FF;
            22: return 30'h000000FF;
            23: return 30'h0000007F;
            24: return 30'h0000003F;
            25: return 30'h0000001F;
            26: return 30'h0000000F;
            27: return 30'h00000008;
            28: return 30'h00000004;
            29: return 30'h00000002;
            default: return 30'h0;
        endcase
    endfunction

    // {overflow, value} of a signed value clamped to DW bits
    function automatic logic [DW:0] sat_w(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return {1'b1, hi[DW-1:0]};
        if (v < lo) return {1'b1, lo[DW-1:0]};
        return {1'b0, v[DW-1:0]};
    endfunction

    // {overflow, value} from a magnitude and a sign
    function automatic logic [DW:0] from_mag(input logic [39:0] m, input logic neg);
        logic [39:0] hi;
        logic [39:0] nm;
        hi = (40'd1 << (DW - 1)) - 40'd1;
        nm = -m;
        if (!neg) begin
            if (m > hi) return {1'b1, hi[DW-1:0]};
            return {1'b0, m[DW-1:0]};
        end
        if (m > hi + 40'd1) return {1'b1, 1'b1, {(DW-1){1'b0}}};
        return {1'b0, nm[DW-1:0]};
    endfunction

endpackage

`default_nettype wire

[hdl/complex_arithmetic_unit.sv]
// Complex arithmetic unit: pipelined fixed-point complex ALU with restoring
// divider, square root and CORDIC stages. Depends on cau_pkg.
//
//  channel   ports                       direction  qualifier
//  command   i_start, i_item (t_in)      in         i_start & !o_busy
//  result    o_done, o_result (t_out)    out        o_done, one cycle
//
// One word enters every cycle; o_busy stays low. Each word passes stage 1,
// stage 2, ITER iteration stages and the output register, with ITER set by
// the 17 quotient steps of the divider, one step per stage. Results come out
// in order and cannot be held off. Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire cau_pkg::t_in  i_item,
    output logic               o_busy,
    output logic               o_done,
    output cau_pkg::t_out      o_result
);
    import cau_pkg::*;

    // stage 1: products and operand prep
    logic                        r_v1;
    t_side                       r_sd1;
    logic signed [2*DW-1:0]      r_p_aa, r_p_bb, r_p_ab, r_p_ba, r_q_re, r_q_im;
    logic signed [PL_W-1:0]      r_px0;
    logic signed [AZ_W-1:0]      r_pz0, r_hz0;
    logic signed [PX_W-1:0]      r_hx0, r_hy0;
    logic                        r_hzero0;

    // stage 2 singles used by the first iteration stage
    logic [2*DW-1:0]             r_nm_re, r_nm_im;
    logic                        r_ng_re, r_ng_im;

    // iteration pipeline
    logic [ITER:0]               r_vld;
    t_side                       r_sd       [0:ITER];
    logic [2*DW-1:0]             r_dv_rem_re[0:ITER];
    logic [2*DW-1:0]             r_dv_rem_im[0:ITER];
    logic [DIV_BITS-1:0]         r_dv_q_re  [0:ITER];
    logic [DIV_BITS-1:0]         r_dv_q_im  [0:ITER];
    logic [DIV_PRE-1:0]          r_dv_nb_re [0:ITER];
    logic [DIV_PRE-1:0]          r_dv_nb_im [0:ITER];
    logic                        r_dv_ng_re [0:ITER];
    logic                        r_dv_ng_im [0:ITER];
    logic                        r_dv_big_re[0:ITER];
    logic                        r_dv_big_im[0:ITER];
    logic [2*DW-1:0]             r_dv_d     [0:ITER];
    logic [2*DW-1:0]             r_sq_s     [0:ITER];
    logic [DW+1:0]               r_sq_rem   [0:ITER];
    logic [DW-1:0]               r_sq_root  [0:ITER];
    logic signed [PX_W-1:0]      r_hx       [0:ITER];
    logic signed [PX_W-1:0]      r_hy       [0:ITER];
    logic signed [AZ_W-1:0]      r_hz       [0:ITER];
    logic                        r_hzero    [0:ITER];
    logic signed [PL_W-1:0]      r_px       [0:ITER];
    logic signed [PL_W-1:0]      r_py       [0:ITER];
    logic signed [AZ_W-1:0]      r_pz       [0:ITER];
    logic                        r_pflip    [0:ITER];

    t_out                        r_out, n_out;
    logic                        r_done;

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_out;

    // ---------------- stage 1 ----------------
    logic signed [DW-1:0]   c_ar, c_ai, c_br, c_bi, c_m0, c_m1;
    logic signed [DW:0]     c_ax, c_ay;
    t_side                  n_sd1;
    logic [DW:0]            c_s0, c_s1;

    always_comb begin
        c_ar = i_item.a_re;
        c_ai = i_item.a_im;
        c_br = i_item.b_re;
        c_bi = i_item.b_im;
        c_m0 = (i_item.mode == MODE_MAG) ? c_ar : c_br;
        c_m1 = (i_item.mode == MODE_MAG) ? c_ai : c_bi;
        c_ax = c_ar[DW-1] ? -(DW+1)'(c_ar) : (DW+1)'(c_ar);
        c_ay = c_ar[DW-1] ? -(DW+1)'(c_ai) : (DW+1)'(c_ai);
        c_s0 = '0;
        c_s1 = '0;
        case (i_item.mode)
            MODE_ADD: begin
                c_s0 = sat_w(64'(c_ar) + 64'(c_br));
                c_s1 = sat_w(64'(c_ai) + 64'(c_bi));
            end
            MODE_SUB: begin
                c_s0 = sat_w(64'(c_ar) - 64'(c_br));
                c_s1 = sat_w(64'(c_ai) - 64'(c_bi));
            end
            MODE_CONJ: begin
                c_s0 = {1'b0, c_ar};
                c_s1 = sat_w(-64'(c_ai));
            end
            MODE_NEG: begin
                c_s0 = sat_w(-64'(c_ar));
                c_s1 = sat_w(-64'(c_ai));
            end
            default: begin
                c_s0 = '0;
                c_s1 = '0;
            end
        endcase
        n_sd1.mode = i_item.mode;
        n_sd1.s_re = c_s0[DW-1:0];
        n_sd1.s_im = c_s1[DW-1:0];
        n_sd1.s_ov = c_s0[DW] | c_s1[DW];
    end

    always_ff @(posedge i_clk) begin
        r_sd1    <= n_sd1;
        r_p_aa   <= c_ar * c_m0;
        r_p_bb   <= c_ai * c_m1;
        r_p_ab   <= c_ar * c_bi;
        r_p_ba   <= c_ai * c_br;
        r_q_re   <= c_br * c_br;
        r_q_im   <= c_bi * c_bi;
        r_px0    <= c_ar * INV_GAIN;
        r_pz0    <= AZ_W'(c_ai) <<< RS_PH;
        r_hx0    <= PX_W'(c_ax) <<< CG;
        r_hy0    <= PX_W'(c_ay) <<< CG;
        r_hz0    <= !c_ar[DW-1] ? '0 : (!c_ai[DW-1] ? ANG_PI : -ANG_PI);
        r_hzero0 <= (c_ar == '0) && (c_ai == '0);
    end

    // ---------------- stage 2 ----------------
    logic signed [PW-1:0]   c_sum_a, c_dif_a, c_sum_b, c_dif_b, c_n_re, c_n_im;
    logic [PW-1:0]          c_a_re, c_a_im;
    logic signed [AZ_W-1:0] c_zm;

    always_comb begin
        c_sum_a = PW'(r_p_aa) + PW'(r_p_bb);
        c_dif_a = PW'(r_p_aa) - PW'(r_p_bb);
        c_sum_b = PW'(r_p_ab) + PW'(r_p_ba);
        c_dif_b = PW'(r_p_ba) - PW'(r_p_ab);
        c_n_re  = (r_sd1.mode == MODE_MUL) ? c_dif_a : c_sum_a;
        c_n_im  = (r_sd1.mode == MODE_MUL) ? c_sum_b : c_dif_b;
        c_a_re  = c_n_re[PW-1] ? PW'(-c_n_re) : PW'(c_n_re);
        c_a_im  = c_n_im[PW-1] ? PW'(-c_n_im) : PW'(c_n_im);
        // angle modulo two pi, truncating toward zero
        if (r_pz0 >= ANG_TWO_PI) begin
            c_zm = r_pz0 - ANG_TWO_PI;
        end else if (r_pz0 <= -ANG_TWO_PI) begin
            c_zm = r_pz0 + ANG_TWO_PI;
        end else begin
            c_zm = r_pz0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0]        <= r_sd1;
        r_nm_re        <= c_a_re[2*DW-1:0];
        r_nm_im        <= c_a_im[2*DW-1:0];
        r_ng_re        <= c_n_re[PW-1];
        r_ng_im        <= c_n_im[PW-1];
        r_dv_rem_re[0] <= c_a_re[2*DW-1:0] >> DIV_PRE;
        r_dv_rem_im[0] <= c_a_im[2*DW-1:0] >> DIV_PRE;
        r_dv_nb_re[0]  <= c_a_re[DIV_PRE-1:0];
        r_dv_nb_im[0]  <= c_a_im[DIV_PRE-1:0];
        r_dv_q_re[0]   <= '0;
        r_dv_q_im[0]   <= '0;
        r_dv_ng_re[0]  <= c_n_re[PW-1];
        r_dv_ng_im[0]  <= c_n_im[PW-1];
        r_dv_big_re[0] <= 1'b0;
        r_dv_big_im[0] <= 1'b0;
        r_dv_d[0]      <= r_q_re + r_q_im;
        r_sq_s[0]      <= c_sum_a[2*DW-1:0];
        r_sq_rem[0]    <= '0;
        r_sq_root[0]   <= '0;
        r_hx[0]        <= r_hx0;
        r_hy[0]        <= r_hy0;
        r_hz[0]        <= r_hz0;
        r_hzero[0]     <= r_hzero0;
        r_px[0]        <= r_px0;
        r_py[0]        <= '0;
        r_pz[0]        <= c_zm;
        r_pflip[0]     <= 1'b0;
    end

    // ---------------- iteration stages ----------------
    for (genvar k = 0; k < ITER; k++) begin : g_stage
        logic [2*DW:0]          dt_re, dt_im, dd_re, dd_im;
        logic                   dge_re, dge_im;
        logic [DW+3:0]          st, stri, sd;
        logic                   sge;
        logic signed [PX_W-1:0] hxs, hys;
        logic signed [PL_W-1:0] pxs, pys;
        logic signed [AZ_W-1:0] ang;
        logic [2*DW-FB:0]       mr_re, mr_im;
        logic [DW:0]            mf_re, mf_im;
        t_side                  nsd;
        logic [2*DW-1:0]        n_rem_re, n_rem_im;
        logic [DIV_BITS-1:0]    n_q_re, n_q_im;
        logic                   n_big_re, n_big_im;
        logic [DW+1:0]          n_srem;
        logic [DW-1:0]          n_sroot;
        logic signed [PX_W-1:0] n_hx, n_hy;
        logic signed [AZ_W-1:0] n_hz, n_pz;
        logic signed [PL_W-1:0] n_px, n_py;
        logic                   n_pflip;

        always_comb begin
            // divider: one quotient bit per stage for each part
            dt_re  = {r_dv_rem_re[k], r_dv_nb_re[k][DIV_PRE-1]};
            dt_im  = {r_dv_rem_im[k], r_dv_nb_im[k][DIV_PRE-1]};
            dge_re = dt_re >= {1'b0, r_dv_d[k]};
            dge_im = dt_im >= {1'b0, r_dv_d[k]};
            dd_re  = dt_re - {1'b0, r_dv_d[k]};
            dd_im  = dt_im - {1'b0, r_dv_d[k]};
            n_rem_re = r_dv_rem_re[k];
            n_rem_im = r_dv_rem_im[k];
            n_q_re   = r_dv_q_re[k];
            n_q_im   = r_dv_q_im[k];
            if (k < DIV_BITS) begin
                n_rem_re = dge_re ? dd_re[2*DW-1:0] : dt_re[2*DW-1:0];
                n_rem_im = dge_im ? dd_im[2*DW-1:0] : dt_im[2*DW-1:0];
                n_q_re   = {r_dv_q_re[k][DIV_BITS-2:0], dge_re};
                n_q_im   = {r_dv_q_im[k][DIV_BITS-2:0], dge_im};
            end
            n_big_re = r_dv_big_re[k];
            n_big_im = r_dv_big_im[k];
            if (k == 0) begin
                // quotient would not fit the resolved bits: saturate
                n_big_re = (2*DW+DIV_PRE)'(r_nm_re) >= {r_dv_d[k], {DIV_PRE{1'b0}}};
                n_big_im = (2*DW+DIV_PRE)'(r_nm_im) >= {r_dv_d[k], {DIV_PRE{1'b0}}};
            end

            // square root: one result bit per stage
            st   = {r_sq_rem[k], r_sq_s[k][2*DW-1:2*DW-2]};
            stri = (DW+4)'({r_sq_root[k], 2'b01});
            sge  = st >= stri;
            sd   = st - stri;
            n_srem  = r_sq_rem[k];
            n_sroot = r_sq_root[k];
            if (k < DW) begin
                n_srem  = sge ? sd[DW+1:0] : st[DW+1:0];
                n_sroot = {r_sq_root[k][DW-2:0], sge};
            end

            // vectoring CORDIC for the phase
            ang  = AZ_W'(atan_ang(k));
            hxs  = r_hx[k] >>> k;
            hys  = r_hy[k] >>> k;
            n_hx = r_hx[k];
            n_hy = r_hy[k];
            n_hz = r_hz[k];
            if (k < CS) begin
                if (!r_hy[k][PX_W-1]) begin
                    n_hx = r_hx[k] + hys;
                    n_hy = r_hy[k] - hxs;
                    n_hz = r_hz[k] + ang;
                end else begin
                    n_hx = r_hx[k] - hys;
                    n_hy = r_hy[k] + hxs;
                    n_hz = r_hz[k] - ang;
                end
            end

            // rotation CORDIC: wrap, fold, steps, then undo the fold
            pxs     = r_px[k] >>> (k >= 2 ? k - 2 : 0);
            pys     = r_py[k] >>> (k >= 2 ? k - 2 : 0);
            n_px    = r_px[k];
            n_py    = r_py[k];
            n_pz    = r_pz[k];
            n_pflip = r_pflip[k];
            if (k == 0) begin
                if (r_pz[k] > ANG_PI) begin
                    n_pz = r_pz[k] - ANG_TWO_PI;
                end else if (r_pz[k] < -ANG_PI) begin
                    n_pz = r_pz[k] + ANG_TWO_PI;
                end
            end else if (k == 1) begin
                if (r_pz[k] > ANG_HALF_PI) begin
                    n_pz    = r_pz[k] - ANG_PI;
                    n_pflip = 1'b1;
                end else if (r_pz[k] < -ANG_HALF_PI) begin
                    n_pz    = r_pz[k] + ANG_PI;
                    n_pflip = 1'b1;
                end
            end else if (k < CS + 2) begin
                if (!r_pz[k][AZ_W-1]) begin
                    n_px = r_px[k] - pys;
                    n_py = r_py[k] + pxs;
                    n_pz = r_pz[k] - AZ_W'(atan_ang(k - 2));
                end else begin
                    n_px = r_px[k] + pys;
                    n_py = r_py[k] - pxs;
                    n_pz = r_pz[k] + AZ_W'(atan_ang(k - 2));
                end
            end else if (k == CS + 2) begin
                if (r_pflip[k]) begin
                    n_px = -r_px[k];
                    n_py = -r_py[k];
                end
            end

            // product rounding, ties away from zero
            mr_re = (2*DW-FB+1)'(({1'b0, r_nm_re} + (2*DW+1)'(1 << (FB - 1))) >> FB);
            mr_im = (2*DW-FB+1)'(({1'b0, r_nm_im} + (2*DW+1)'(1 << (FB - 1))) >> FB);
            mf_re = from_mag(40'(mr_re), r_ng_re);
            mf_im = from_mag(40'(mr_im), r_ng_im);
            nsd   = r_sd[k];
            if (k == 0 && r_sd[k].mode == MODE_MUL) begin
                nsd.s_re = mf_re[DW-1:0];
                nsd.s_im = mf_im[DW-1:0];
                nsd.s_ov = mf_re[DW] | mf_im[DW];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sd[k+1]        <= nsd;
            r_dv_rem_re[k+1] <= n_rem_re;
            r_dv_rem_im[k+1] <= n_rem_im;
            r_dv_q_re[k+1]   <= n_q_re;
            r_dv_q_im[k+1]   <= n_q_im;
            r_dv_nb_re[k+1]  <= r_dv_nb_re[k] << 1;
            r_dv_nb_im[k+1]  <= r_dv_nb_im[k] << 1;
            r_dv_ng_re[k+1]  <= r_dv_ng_re[k];
            r_dv_ng_im[k+1]  <= r_dv_ng_im[k];
            r_dv_big_re[k+1] <= n_big_re;
            r_dv_big_im[k+1] <= n_big_im;
            r_dv_d[k+1]      <= r_dv_d[k];
            r_sq_s[k+1]      <= r_sq_s[k] << 2;
            r_sq_rem[k+1]    <= n_srem;
            r_sq_root[k+1]   <= n_sroot;
            r_hx[k+1]        <= n_hx;
            r_hy[k+1]        <= n_hy;
            r_hz[k+1]        <= n_hz;
            r_hzero[k+1]     <= r_hzero[k];
            r_px[k+1]        <= n_px;
            r_py[k+1]        <= n_py;
            r_pz[k+1]        <= n_pz;
            r_pflip[k+1]     <= n_pflip;
        end
    end

    // ---------------- output stage ----------------
    logic                   f_rr_re, f_rr_im, f_sr;
    logic [DIV_BITS:0]      f_q_re, f_q_im;
    logic [DW:0]            f_root;
    logic [DW:0]            f_0, f_1;
    logic signed [AZ_W-1:0] f_ph;
    logic signed [PL_W-1:0] f_px, f_py;
    logic                   f_dz;

    always_comb begin
        f_rr_re = {r_dv_rem_re[ITER], 1'b0} >= {1'b0, r_dv_d[ITER]};
        f_rr_im = {r_dv_rem_im[ITER], 1'b0} >= {1'b0, r_dv_d[ITER]};
        f_q_re  = (DIV_BITS+1)'(r_dv_q_re[ITER]) + (DIV_BITS+1)'(f_rr_re);
        f_q_im  = (DIV_BITS+1)'(r_dv_q_im[ITER]) + (DIV_BITS+1)'(f_rr_im);
        f_dz    = (r_dv_d[ITER] == '0);
        f_sr    = (DW+2)'(r_sq_rem[ITER]) > (DW+2)'(r_sq_root[ITER]);
        f_root  = (DW+1)'(r_sq_root[ITER]) + (DW+1)'(f_sr);
        f_ph    = (r_hz[ITER] + (AZ_W'(1) <<< (RS_PH - 1))) >>> RS_PH;
        f_px    = (r_px[ITER] + (PL_W'(1) <<< 29)) >>> 30;
        f_py    = (r_py[ITER] + (PL_W'(1) <<< 29)) >>> 30;
        f_0     = '0;
        f_1     = '0;
        n_out.res_re = '0;
        n_out.res_im = '0;
        n_out.status = ST_OK;
        case (r_sd[ITER].mode)
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_CONJ, MODE_NEG: begin
                n_out.res_re = r_sd[ITER].s_re;
                n_out.res_im = r_sd[ITER].s_im;
                n_out.status = r_sd[ITER].s_ov ? ST_SAT : ST_OK;
            end
            MODE_DIV: begin
                f_0 = from_mag(r_dv_big_re[ITER] ? '1 : 40'(f_q_re), r_dv_ng_re[ITER]);
                f_1 = from_mag(r_dv_big_im[ITER] ? '1 : 40'(f_q_im), r_dv_ng_im[ITER]);
                if (f_dz) begin
                    n_out.status = ST_DIVZ;
                end else begin
                    n_out.res_re = f_0[DW-1:0];
                    n_out.res_im = f_1[DW-1:0];
                    n_out.status = (f_0[DW] | f_1[DW]) ? ST_SAT : ST_OK;
                end
            end
            MODE_MAG: begin
                f_0 = from_mag(40'(f_root), 1'b0);
                n_out.res_re = f_0[DW-1:0];
                n_out.status = f_0[DW] ? ST_SAT : ST_OK;
            end
            MODE_PHASE: begin
                f_0 = r_hzero[ITER] ? '0 : sat_w(64'(f_ph));
                n_out.res_re = f_0[DW-1:0];
                n_out.status = f_0[DW] ? ST_SAT : ST_OK;
            end
            MODE_POLAR: begin
                f_0 = sat_w(64'(f_px));
                f_1 = sat_w(64'(f_py));
                n_out.res_re = f_0[DW-1:0];
                n_out.res_im = f_1[DW-1:0];
                n_out.status = (f_0[DW] | f_1[DW]) ? ST_SAT : ST_OK;
            end
            default: begin
                n_out.res_re = '0;
                n_out.res_im = '0;
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_vld  <= {r_vld[ITER-1:0], r_v1};
            r_done <= r_vld[ITER];
        end
    end

    // ---------------- assertions ----------------
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_DIVZ) |->
            (o_result.res_re == '0 && o_result.res_im == '0))
        else $error("divide-by-zero result is not zero");

    a_scalar_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(r_sd[ITER].mode) == MODE_MAG ||
                    $past(r_sd[ITER].mode) == MODE_PHASE)) |->
            o_result.res_im == '0)
        else $error("scalar result has a nonzero imaginary part");

    a_mag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_sd[ITER].mode) == MODE_MAG) |->
            !o_result.res_re[DW-1])
        else $error("magnitude is negative");

endmodule

`default_nettype wire
